// ===== src/cedec_pkg.sv =====
// Shared types for the cached example decoder: result kinds and the result record.
package cedec_pkg;

    typedef enum logic [2:0] {
        KIND_LABEL     = 3'd0,
        KIND_WEIGHT    = 3'd1,
        KIND_TAG       = 3'd2,
        KIND_NS_HEADER = 3'd3,
        KIND_FEATURE   = 3'd4,
        KIND_TRUNCATED = 3'd5,
        KIND_OVERRUN   = 3'd6
    } kind_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  namespace_id;
        logic [31:0] feature_index;
        logic [31:0] value_bits;
        logic        last_of_example;
    } result_t;

endpackage

// ===== src/cedec_core.sv =====
// Parser state and per-byte decode step of the cached example decoder.
module cedec_core
    import cedec_pkg::*;
#(
    parameter int INDEX_BITS         = 32,
    parameter int LENGTH_FIELD_BYTES = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  logic [7:0] data_byte,
    input  logic    stream_end,
    output result_t res
);

    localparam logic [31:0] VAL_NEG_ONE = 32'hBF80_0000;
    localparam logic [31:0] VAL_POS_ONE = 32'h3F80_0000;
    localparam logic [3:0]  LEN_BYTES   = 4'(LENGTH_FIELD_BYTES);

    typedef enum logic [3:0] {
        PH_LABEL   = 4'd0,
        PH_WEIGHT  = 4'd1,
        PH_NSCOUNT = 4'd2,
        PH_TAGLEN  = 4'd3,
        PH_TAG     = 4'd4,
        PH_NSID    = 4'd5,
        PH_NSLEN   = 4'd6,
        PH_FEAT    = 4'd7,
        PH_FVAL    = 4'd8
    } phase_t;

    typedef struct packed {
        logic [63:0] value;
        logic [6:0]  shift;
        logic        done;
    } varint_t;

    // One LEB128 byte: bits past bit 63 are dropped and the shift saturates at 64.
    function automatic varint_t varint_feed(input logic [63:0] v, input logic [6:0] s,
                                            input logic [7:0] b);
        varint_t     r;
        logic [63:0] part;
        part    = 64'(b[6:0]) << s[5:0];
        r.value = s[6] ? v : (v | part);
        r.shift = (s >= 7'd57) ? 7'd64 : s + 7'd7;
        r.done  = !b[7];
        return r;
    endfunction

    function automatic logic [31:0] index_low(input logic [INDEX_BITS-1:0] x);
        logic [63:0] ext;
        ext = 64'(x);
        return ext[31:0];
    endfunction

    phase_t                  phase_reg, phase_next;
    logic [3:0]              byte_count_reg, byte_count_next;
    logic [63:0]             assembly_reg, assembly_next;
    logic [63:0]             varint_value_reg, varint_value_next;
    logic [6:0]              varint_shift_reg, varint_shift_next;
    logic [63:0]             namespaces_left_reg, namespaces_left_next;
    logic [63:0]             tag_left_reg, tag_left_next;
    logic [63:0]             storage_left_reg, storage_left_next;
    logic [INDEX_BITS-1:0]   previous_index_reg, previous_index_next;
    logic [7:0]              current_namespace_reg, current_namespace_next;
    logic [INDEX_BITS-1:0]   pending_index_reg, pending_index_next;

    varint_t                 vi;
    logic [63:0]             col_asm;
    logic [3:0]              col_cnt;
    logic [63:0]             storage_dec;
    logic [63:0]             ns_dec;
    logic [63:0]             tag_dec;
    logic [63:0]             delta;
    logic [INDEX_BITS-1:0]   idx_sum;
    logic                    example_done;
    logic                    overrun;
    logic                    bad_phase;
    logic                    end_ns;

    always_comb
    begin
        vi          = varint_feed(varint_value_reg, varint_shift_reg, data_byte);
        col_asm     = assembly_reg | (64'(data_byte) << {byte_count_reg[2:0], 3'b000});
        col_cnt     = byte_count_reg + 4'd1;
        storage_dec = (storage_left_reg != 64'd0) ? storage_left_reg - 64'd1 : 64'd0;
        ns_dec      = (namespaces_left_reg != 64'd0) ? namespaces_left_reg - 64'd1 : 64'd0;
        tag_dec     = (tag_left_reg != 64'd0) ? tag_left_reg - 64'd1 : 64'd0;
        delta       = vi.value >> 2;
        idx_sum     = previous_index_reg + delta[INDEX_BITS-1:0];

        phase_next             = phase_reg;
        byte_count_next        = byte_count_reg;
        assembly_next          = assembly_reg;
        varint_value_next      = varint_value_reg;
        varint_shift_next      = varint_shift_reg;
        namespaces_left_next   = namespaces_left_reg;
        tag_left_next          = tag_left_reg;
        storage_left_next      = storage_left_reg;
        previous_index_next    = previous_index_reg;
        current_namespace_next = current_namespace_reg;
        pending_index_next     = pending_index_reg;

        res          = '0;
        res.kind     = KIND_LABEL;
        example_done = 1'b0;
        overrun      = 1'b0;
        bad_phase    = 1'b0;
        end_ns       = 1'b0;

        case (phase_reg)
            PH_LABEL, PH_WEIGHT:
            begin
                assembly_next   = col_asm;
                byte_count_next = col_cnt;
                if (col_cnt >= 4'd4)
                begin
                    res.valid       = 1'b1;
                    res.kind        = (phase_reg == PH_LABEL) ? KIND_LABEL : KIND_WEIGHT;
                    res.value_bits  = col_asm[31:0];
                    assembly_next   = '0;
                    byte_count_next = '0;
                    phase_next      = (phase_reg == PH_LABEL) ? PH_WEIGHT : PH_NSCOUNT;
                end
            end
            PH_NSCOUNT:
            begin
                varint_value_next = vi.value;
                varint_shift_next = vi.shift;
                if (vi.done)
                begin
                    namespaces_left_next = vi.value;
                    varint_value_next    = '0;
                    varint_shift_next    = '0;
                    phase_next           = PH_TAGLEN;
                end
            end
            PH_TAGLEN:
            begin
                varint_value_next = vi.value;
                varint_shift_next = vi.shift;
                if (vi.done)
                begin
                    tag_left_next     = vi.value;
                    varint_value_next = '0;
                    varint_shift_next = '0;
                    if (vi.value != 64'd0)
                        phase_next = PH_TAG;
                    else if (namespaces_left_reg != 64'd0)
                        phase_next = PH_NSID;
                    else
                    begin
                        phase_next   = PH_LABEL;
                        example_done = 1'b1;
                    end
                end
            end
            PH_TAG:
            begin
                tag_left_next       = tag_dec;
                res.valid           = 1'b1;
                res.kind            = KIND_TAG;
                res.value_bits      = 32'(data_byte);
                res.last_of_example = (tag_dec == 64'd0) && (namespaces_left_reg == 64'd0);
                if (tag_dec == 64'd0)
                begin
                    if (namespaces_left_reg != 64'd0)
                        phase_next = PH_NSID;
                    else
                    begin
                        phase_next   = PH_LABEL;
                        example_done = 1'b1;
                    end
                end
            end
            PH_NSID:
            begin
                varint_value_next = vi.value;
                varint_shift_next = vi.shift;
                if (vi.done)
                begin
                    current_namespace_next = vi.value[7:0];
                    varint_value_next      = '0;
                    varint_shift_next      = '0;
                    assembly_next          = '0;
                    byte_count_next        = '0;
                    phase_next             = PH_NSLEN;
                end
            end
            PH_NSLEN:
            begin
                assembly_next   = col_asm;
                byte_count_next = col_cnt;
                if (col_cnt >= LEN_BYTES)
                begin
                    storage_left_next   = col_asm;
                    assembly_next       = '0;
                    byte_count_next     = '0;
                    previous_index_next = '0;
                    res.valid           = 1'b1;
                    res.kind            = KIND_NS_HEADER;
                    res.namespace_id    = current_namespace_reg;
                    res.last_of_example = (col_asm == 64'd0) && (namespaces_left_reg <= 64'd1);
                    if (col_asm == 64'd0)
                        end_ns = 1'b1;
                    else
                        phase_next = PH_FEAT;
                end
            end
            PH_FEAT:
            begin
                storage_left_next = storage_dec;
                varint_value_next = vi.value;
                varint_shift_next = vi.shift;
                if (vi.done)
                begin
                    varint_value_next   = '0;
                    varint_shift_next   = '0;
                    previous_index_next = idx_sum;
                    if (vi.value[0] || !vi.value[1])
                    begin
                        res.valid           = 1'b1;
                        res.kind            = KIND_FEATURE;
                        res.namespace_id    = current_namespace_reg;
                        res.feature_index   = index_low(idx_sum);
                        res.value_bits      = vi.value[0] ? VAL_NEG_ONE : VAL_POS_ONE;
                        res.last_of_example = (storage_dec == 64'd0) &&
                                              (namespaces_left_reg <= 64'd1);
                        if (storage_dec == 64'd0)
                            end_ns = 1'b1;
                        else
                            phase_next = PH_FEAT;
                    end
                    else if (storage_dec < 64'd4)
                        overrun = 1'b1;
                    else
                    begin
                        pending_index_next = idx_sum;
                        assembly_next      = '0;
                        byte_count_next    = '0;
                        phase_next         = PH_FVAL;
                    end
                end
                else if (storage_dec == 64'd0)
                    overrun = 1'b1;
            end
            PH_FVAL:
            begin
                storage_left_next = storage_dec;
                assembly_next     = col_asm;
                byte_count_next   = col_cnt;
                if (col_cnt >= 4'd4)
                begin
                    assembly_next       = '0;
                    byte_count_next     = '0;
                    res.valid           = 1'b1;
                    res.kind            = KIND_FEATURE;
                    res.namespace_id    = current_namespace_reg;
                    res.feature_index   = index_low(pending_index_reg);
                    res.value_bits      = col_asm[31:0];
                    res.last_of_example = (storage_dec == 64'd0) &&
                                          (namespaces_left_reg <= 64'd1);
                    if (storage_dec == 64'd0)
                        end_ns = 1'b1;
                    else
                        phase_next = PH_FEAT;
                end
            end
            default:
            begin
                bad_phase = 1'b1;
            end
        endcase

        // Closing a namespace: the example ends when none are left.
        if (end_ns)
        begin
            namespaces_left_next = ns_dec;
            if (ns_dec == 64'd0)
            begin
                phase_next   = PH_LABEL;
                example_done = 1'b1;
            end
            else
                phase_next = PH_NSID;
        end

        if (overrun)
        begin
            res                 = '0;
            res.valid           = 1'b1;
            res.kind            = KIND_OVERRUN;
            res.namespace_id    = current_namespace_next;
            res.last_of_example = 1'b1;
        end
        else if (stream_end && !example_done && !bad_phase)
        begin
            res                 = '0;
            res.valid           = 1'b1;
            res.kind            = KIND_TRUNCATED;
            res.namespace_id    = current_namespace_next;
            res.last_of_example = 1'b1;
        end

        if (overrun || bad_phase || example_done || stream_end)
        begin
            phase_next           = PH_LABEL;
            byte_count_next      = '0;
            assembly_next        = '0;
            varint_value_next    = '0;
            varint_shift_next    = '0;
            namespaces_left_next = '0;
            tag_left_next        = '0;
            storage_left_next    = '0;
            previous_index_next  = '0;
            pending_index_next   = '0;
            // A clean example end keeps the namespace; every other path clears it.
            if (overrun || bad_phase || !example_done)
                current_namespace_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_LABEL;
            byte_count_reg        <= '0;
            assembly_reg          <= '0;
            varint_value_reg      <= '0;
            varint_shift_reg      <= '0;
            namespaces_left_reg   <= '0;
            tag_left_reg          <= '0;
            storage_left_reg      <= '0;
            previous_index_reg    <= '0;
            current_namespace_reg <= '0;
            pending_index_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg             <= phase_next;
            byte_count_reg        <= byte_count_next;
            assembly_reg          <= assembly_next;
            varint_value_reg      <= varint_value_next;
            varint_shift_reg      <= varint_shift_next;
            namespaces_left_reg   <= namespaces_left_next;
            tag_left_reg          <= tag_left_next;
            storage_left_reg      <= storage_left_next;
            previous_index_reg    <= previous_index_next;
            current_namespace_reg <= current_namespace_next;
            pending_index_reg     <= pending_index_next;
        end
    end

    // An error item returns the parser to the start of an example.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && res.valid && (res.kind == KIND_TRUNCATED || res.kind == KIND_OVERRUN)
        |=> phase_reg == PH_LABEL && byte_count_reg == 4'd0 && storage_left_reg == 64'd0)
        else $error("parser not cleared after an error item");

    // Error items always close the example.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.kind == KIND_TRUNCATED || res.kind == KIND_OVERRUN)
        |-> res.last_of_example)
        else $error("error item without end-of-example flag");

    // A float value is collected in at most four bytes and only with storage to cover them.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FVAL |-> byte_count_reg < 4'd4 &&
            storage_left_reg >= 64'(4'd4 - byte_count_reg))
        else $error("float value collection out of bounds");

endmodule

// ===== src/cached_example_decoder.sv =====
// Top level of the cached example decoder: input request register, parser core, result register.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  input   | in_valid, in_ready, data_byte, stream_end       | in
//  result  | out_valid, out_ready, kind, namespace_id,       | out
//          | feature_index, value_bits, last_of_example      |
//
// One input request is taken every cycle while results are being drained. A byte accepted
// into the input register is decoded from there once the result slot is free or being emptied,
// and its result is offered from the result register; a byte with no result just leaves.
// The asynchronous reset puts the parser at the start of an example with all counters cleared.
// While a result waits untaken, the byte in the input register is held, and in_ready drops
// once that register is also occupied.
module cached_example_decoder
    import cedec_pkg::*;
#(
    parameter int INDEX_BITS         = 32,
    parameter int LENGTH_FIELD_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        stream_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  namespace_id,
    output logic [31:0] feature_index,
    output logic [31:0] value_bits,
    output logic        last_of_example
);

    logic       in_valid_reg;
    logic [7:0] data_reg;
    logic       end_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    res;
    logic       advance;

    // The byte in the input register is decoded when the result slot is free
    // or is being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    cedec_core #(
        .INDEX_BITS        (INDEX_BITS),
        .LENGTH_FIELD_BYTES(LENGTH_FIELD_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (data_reg),
        .stream_end(end_reg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= res.valid;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_byte;
            end_reg  <= stream_end;
        end
        if (advance && res.valid)
            out_reg <= res;
    end

    assign out_valid       = out_valid_reg;
    assign kind            = out_reg.kind;
    assign namespace_id    = out_reg.namespace_id;
    assign feature_index   = out_reg.feature_index;
    assign value_bits      = out_reg.value_bits;
    assign last_of_example = out_reg.last_of_example;

    // With the result slot empty the block can always take a new request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with an empty result register");

    // A stalled result keeps the input register from being decoded.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !advance)
        else $error("byte decoded while a result waits");

    // A held byte that produces a result always lands in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.valid |=> out_valid_reg)
        else $error("decoded result lost");

endmodule

// ===== tb/tb_cached_example_decoder.sv =====
// Self-checking testbench for the cached example decoder: byte streams in, decoded items out.
module tb_cached_example_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import cedec_pkg::*;

    // The storage length field of a namespace is this many little-endian bytes.
    localparam int LEN_BYTES = 8;
    // Longest stretch without any request moving on either side before the run is
    // declared hung. The deliberate output hold-off is HOLD_CYCLES, far below this.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 200;
    localparam int MAX_REPORTS    = 10;

    localparam logic [31:0] MINUS_ONE = 32'hBF80_0000;
    localparam logic [31:0] PLUS_ONE  = 32'h3F80_0000;

    // Where the parser is within an example. Only the testbench uses these.
    typedef enum logic [3:0] {
        ST_LABEL    = 4'd0,
        ST_WEIGHT   = 4'd1,
        ST_NS_COUNT = 4'd2,
        ST_TAG_LEN  = 4'd3,
        ST_TAG      = 4'd4,
        ST_NS_ID    = 4'd5,
        ST_NS_LEN   = 4'd6,
        ST_FEATURE  = 4'd7,
        ST_FLOAT    = 4'd8
    } parse_state_t;

    // How a generated example is shaped before it is streamed.
    typedef enum int {
        SHAPE_CLEAN,
        SHAPE_CUT,
        SHAPE_SHORT,
        SHAPE_NOISE
    } shape_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  ns;
        logic [31:0] idx;
        logic [31:0] val;
        logic        last;
    } decoded_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        stream_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  namespace_id;
    logic [31:0] feature_index;
    logic [31:0] value_bits;
    logic        last_of_example;

    cached_example_decoder u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .stream_end      (stream_end),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .namespace_id    (namespace_id),
        .feature_index   (feature_index),
        .value_bits      (value_bits),
        .last_of_example (last_of_example)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Parser mirror. Every accepted byte is run through decode_byte, which
    // keeps its own copy of the parse state and queues the item the block
    // must produce for that byte, if any.
    // ------------------------------------------------------------------
    parse_state_t pstate;
    logic [3:0]   nbytes;
    logic [63:0]  acc;
    logic [63:0]  vint;
    logic [6:0]   vshift;
    logic [63:0]  ns_left;
    logic [63:0]  tag_left;
    logic [63:0]  store_left;
    logic [31:0]  prev_idx;
    logic [7:0]   cur_ns;
    logic [31:0]  pend_idx;
    bit           ex_done;
    // Set when the last byte ended in an overrun or truncation report.
    bit           err_seen;

    decoded_t expected_items[$];

    int failures        = 0;
    int results_seen    = 0;
    int bytes_sent      = 0;
    int examples        = 0;
    int broken          = 0;
    int overruns_due    = 0;
    int truncations_due = 0;

    function automatic void clear_state();
        pstate     = ST_LABEL;
        nbytes     = 4'd0;
        acc        = 64'd0;
        vint       = 64'd0;
        vshift     = 7'd0;
        ns_left    = 64'd0;
        tag_left   = 64'd0;
        store_left = 64'd0;
        prev_idx   = 32'd0;
        cur_ns     = 8'd0;
        pend_idx   = 32'd0;
    endfunction

    // One LEB128 byte. Bits past bit 63 fall off and the shift sticks at 64.
    function automatic bit varint_step(input logic [7:0] b);
        if (vshift < 7'd64)
            vint = vint | ({57'd0, b[6:0]} << vshift);
        vshift = (vshift >= 7'd57) ? 7'd64 : vshift + 7'd7;
        return !b[7];
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        acc    = acc | ({56'd0, b} << (8 * nbytes[2:0]));
        nbytes = nbytes + 4'd1;
    endfunction

    function automatic decoded_t make_item(input kind_t k, input logic [7:0] ns,
                                           input logic [31:0] idx, input logic [31:0] val,
                                           input logic last);
        decoded_t it;
        it.kind = k;
        it.ns   = ns;
        it.idx  = idx;
        it.val  = val;
        it.last = last;
        return it;
    endfunction

    function automatic void close_namespace();
        if (ns_left != 64'd0)
            ns_left = ns_left - 64'd1;
        if (ns_left == 64'd0)
        begin
            pstate  = ST_LABEL;
            ex_done = 1'b1;
        end
        else
            pstate = ST_NS_ID;
    endfunction

    function automatic decoded_t feature_item(input logic [31:0] idx, input logic [31:0] v);
        decoded_t it;
        it = make_item(KIND_FEATURE, cur_ns, idx, v, store_left == 64'd0 && ns_left <= 64'd1);
        if (store_left == 64'd0)
            close_namespace();
        else
            pstate = ST_FEATURE;
        return it;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last_byte);
        decoded_t    item;
        bit          produced;
        bit          overrun;
        logic [63:0] code;
        logic [7:0]  keep_ns;
        produced = 1'b0;
        overrun  = 1'b0;
        ex_done  = 1'b0;
        err_seen = 1'b0;
        case (pstate)
            ST_LABEL, ST_WEIGHT:
            begin
                take_byte(b);
                if (nbytes >= 4'd4)
                begin
                    item = make_item((pstate == ST_LABEL) ? KIND_LABEL : KIND_WEIGHT,
                                     8'd0, 32'd0, acc[31:0], 1'b0);
                    produced = 1'b1;
                    acc      = 64'd0;
                    nbytes   = 4'd0;
                    pstate   = (pstate == ST_LABEL) ? ST_WEIGHT : ST_NS_COUNT;
                end
            end
            ST_NS_COUNT:
            begin
                if (varint_step(b))
                begin
                    ns_left = vint;
                    vint    = 64'd0;
                    vshift  = 7'd0;
                    pstate  = ST_TAG_LEN;
                end
            end
            ST_TAG_LEN:
            begin
                if (varint_step(b))
                begin
                    tag_left = vint;
                    vint     = 64'd0;
                    vshift   = 7'd0;
                    if (tag_left != 64'd0)
                        pstate = ST_TAG;
                    else if (ns_left != 64'd0)
                        pstate = ST_NS_ID;
                    else
                    begin
                        // Empty tail: the example ends here with nothing flagged.
                        pstate  = ST_LABEL;
                        ex_done = 1'b1;
                    end
                end
            end
            ST_TAG:
            begin
                if (tag_left != 64'd0)
                    tag_left = tag_left - 64'd1;
                item = make_item(KIND_TAG, 8'd0, 32'd0, {24'd0, b},
                                 tag_left == 64'd0 && ns_left == 64'd0);
                produced = 1'b1;
                if (tag_left == 64'd0)
                begin
                    if (ns_left != 64'd0)
                        pstate = ST_NS_ID;
                    else
                    begin
                        pstate  = ST_LABEL;
                        ex_done = 1'b1;
                    end
                end
            end
            ST_NS_ID:
            begin
                if (varint_step(b))
                begin
                    cur_ns = vint[7:0];
                    vint   = 64'd0;
                    vshift = 7'd0;
                    acc    = 64'd0;
                    nbytes = 4'd0;
                    pstate = ST_NS_LEN;
                end
            end
            ST_NS_LEN:
            begin
                take_byte(b);
                if (nbytes >= 4'(LEN_BYTES))
                begin
                    store_left = acc;
                    acc        = 64'd0;
                    nbytes     = 4'd0;
                    prev_idx   = 32'd0;
                    item = make_item(KIND_NS_HEADER, cur_ns, 32'd0, 32'd0,
                                     store_left == 64'd0 && ns_left <= 64'd1);
                    produced = 1'b1;
                    if (store_left == 64'd0)
                        close_namespace();
                    else
                        pstate = ST_FEATURE;
                end
            end
            ST_FEATURE:
            begin
                if (store_left != 64'd0)
                    store_left = store_left - 64'd1;
                if (varint_step(b))
                begin
                    code     = vint;
                    vint     = 64'd0;
                    vshift   = 7'd0;
                    prev_idx = prev_idx + code[33:2];
                    // The minus-one bit wins over the float bit when both are set.
                    if (code[0])
                    begin
                        item     = feature_item(prev_idx, MINUS_ONE);
                        produced = 1'b1;
                    end
                    else if (code[1])
                    begin
                        if (store_left < 64'd4)
                            overrun = 1'b1;
                        else
                        begin
                            pend_idx = prev_idx;
                            acc      = 64'd0;
                            nbytes   = 4'd0;
                            pstate   = ST_FLOAT;
                        end
                    end
                    else
                    begin
                        item     = feature_item(prev_idx, PLUS_ONE);
                        produced = 1'b1;
                    end
                end
                else if (store_left == 64'd0)
                    overrun = 1'b1;
            end
            ST_FLOAT:
            begin
                if (store_left != 64'd0)
                    store_left = store_left - 64'd1;
                take_byte(b);
                if (nbytes >= 4'd4)
                begin
                    code     = acc;
                    acc      = 64'd0;
                    nbytes   = 4'd0;
                    item     = feature_item(pend_idx, code[31:0]);
                    produced = 1'b1;
                end
            end
            default:
            begin
                clear_state();
                return;
            end
        endcase

        if (overrun)
        begin
            expected_items.push_back(make_item(KIND_OVERRUN, cur_ns, 32'd0, 32'd0, 1'b1));
            overruns_due++;
            err_seen = 1'b1;
            clear_state();
        end
        else if (last_byte && !ex_done)
        begin
            // A stream that stops inside an example replaces whatever item was due.
            expected_items.push_back(make_item(KIND_TRUNCATED, cur_ns, 32'd0, 32'd0, 1'b1));
            truncations_due++;
            err_seen = 1'b1;
            clear_state();
        end
        else
        begin
            if (produced)
                expected_items.push_back(item);
            if (ex_done)
            begin
                // The namespace id survives the end of a clean example.
                keep_ns = cur_ns;
                clear_state();
                cur_ns = keep_ns;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Stream building. An example is assembled into stream_q; end_at marks
    // the byte that carries stream_end, or is negative for none.
    // ------------------------------------------------------------------
    logic [7:0] stream_q[$];
    int         end_at;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         holds_asked    = 0;

    function automatic bit coin(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic void put_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            stream_q.push_back(v[8*i +: 8]);
    endfunction

    // LEB128 writer. With pad set, the last group is written with its
    // continuation bit and a zero byte follows, which decodes to the same value.
    function automatic void put_varint(input logic [63:0] v, input bit pad);
        while (v >= 64'd128)
        begin
            stream_q.push_back({1'b1, v[6:0]});
            v = v >> 7;
        end
        if (pad)
        begin
            stream_q.push_back({1'b1, v[6:0]});
            stream_q.push_back(8'h00);
        end
        else
            stream_q.push_back({1'b0, v[6:0]});
    endfunction

    function automatic void build_example();
        shape_t      shape;
        int          pick;
        int          n_ns;
        int          tag_len;
        int          pos;
        int          len;
        logic [63:0] len64;
        logic [31:0] delta;
        logic [1:0]  flags;
        stream_q.delete();
        end_at = -1;
        pick   = $urandom_range(99);
        shape  = (pick < 75) ? SHAPE_CLEAN : (pick < 85) ? SHAPE_CUT :
                 (pick < 95) ? SHAPE_SHORT : SHAPE_NOISE;
        if (shape != SHAPE_CLEAN)
            broken++;
        if (shape == SHAPE_NOISE)
        begin
            repeat ($urandom_range(1, 12))
                stream_q.push_back(8'($urandom_range(255)));
            end_at = stream_q.size() - 1;
            return;
        end
        put_le(64'($urandom()), 4);
        put_le(64'($urandom()), 4);
        n_ns = coin(15) ? 0 : $urandom_range(1, 3);
        put_varint(64'(n_ns), coin(10));
        tag_len = coin(50) ? 0 : $urandom_range(1, 4);
        put_varint(64'(tag_len), coin(10));
        repeat (tag_len)
            stream_q.push_back(8'($urandom_range(255)));
        for (int k = 0; k < n_ns; k++)
        begin
            put_varint(64'(coin(50) ? $urandom_range(255) : $urandom_range(256, 70000)),
                       coin(10));
            pos = stream_q.size();
            repeat ($urandom_range(0, 4))
            begin
                delta = coin(20) ? $urandom() : 32'($urandom_range(40));
                flags = 2'($urandom_range(3));
                put_varint({30'd0, delta, flags}, coin(5));
                if (flags == 2'b10)
                    put_le(64'($urandom()), 4);
            end
            len = stream_q.size() - pos;
            // A storage length that is too short makes the features run past it.
            if (shape == SHAPE_SHORT && len > 0)
                len = len - $urandom_range(1, (len < 4) ? len : 4);
            len64 = 64'(len);
            for (int i = 0; i < LEN_BYTES; i++)
                stream_q.insert(pos + i, len64[8*i +: 8]);
        end
        if (shape == SHAPE_CUT)
            end_at = $urandom_range(stream_q.size() - 1);
        else if (coin(12))
            end_at = stream_q.size() - 1;
    endfunction

    // Offers one request and waits until it is taken, idling beforehand at the
    // current rate. Valid stays up with the same byte until the handshake.
    task automatic send_byte(input logic [7:0] b, input logic last_byte);
        @(negedge clk);
        while (coin(send_idle_pct))
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        data_byte  = b;
        stream_end = last_byte;
        do
            @(posedge clk);
        while (!in_ready);
        decode_byte(b, last_byte);
        bytes_sent++;
    endtask

    // Streams the example in stream_q. After an error report the rest of the
    // example is dropped; a parser left mid-example is brought back to the
    // start with one extra byte that carries stream_end.
    task automatic send_example();
        int stop;
        stop = (end_at >= 0) ? end_at : stream_q.size() - 1;
        for (int i = 0; i <= stop; i++)
        begin
            send_byte(stream_q[i], i == end_at);
            if (err_seen)
                break;
        end
        if (!(pstate == ST_LABEL && nbytes == 4'd0))
            send_byte(8'($urandom_range(255)), 1'b1);
        examples++;
    endtask

    task automatic run_stream(input int src_idle, input int sink_stall, input int n_bytes);
        int start;
        send_idle_pct  = src_idle;
        recv_stall_pct = sink_stall;
        start          = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            build_example();
            send_example();
        end
    endtask

    // ------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------

    // An example with neither tag nor namespaces ends on its tag length byte and
    // produces only the label and weight; label bytes all ones, weight mostly zero.
    task automatic test_empty_tail();
        stream_q.delete();
        end_at = -1;
        put_le(64'hFFFF_FFFF, 4);
        put_le(64'h8000_0000, 4);
        put_varint(64'd0, 1'b0);
        put_varint(64'd0, 1'b0);
        send_example();
    endtask

    // One namespace with a padded count, a tag byte, a two-byte namespace id and
    // one feature of each value form: both flag bits set, a raw float, and a plus
    // one with a two-byte code. The stream ends exactly at the end of the example,
    // which must not be reported as truncation.
    task automatic test_feature_forms();
        stream_q.delete();
        put_le(64'h3F80_0000, 4);
        put_le(64'h0000_0001, 4);
        put_varint(64'd1, 1'b1);
        put_varint(64'd1, 1'b0);
        stream_q.push_back(8'hA5);
        put_varint(64'd300, 1'b0);
        put_le(64'd8, LEN_BYTES);
        put_varint(64'd3, 1'b0);
        put_varint(64'd6, 1'b0);
        put_le(64'hC049_0FDB, 4);
        put_varint(64'd132, 1'b0);
        end_at = stream_q.size() - 1;
        send_example();
    endtask

    // A feature code still open when the namespace storage runs out.
    task automatic test_overrun();
        stream_q.delete();
        end_at = -1;
        put_le(64'h0000_0000, 4);
        put_le(64'h7F7F_FFFF, 4);
        put_varint(64'd2, 1'b0);
        put_varint(64'd0, 1'b0);
        put_varint(64'd255, 1'b0);
        put_le(64'd1, LEN_BYTES);
        stream_q.push_back(8'h80);
        send_example();
    endtask

    // An eleven-byte namespace count drives the varint shift to saturation; the
    // stream then stops on the tag length byte while namespaces are still due.
    task automatic test_truncated_long_count();
        stream_q.delete();
        put_le(64'($urandom()), 4);
        put_le(64'($urandom()), 4);
        repeat (10)
            stream_q.push_back(8'hFF);
        stream_q.push_back(8'h01);
        stream_q.push_back(8'h00);
        end_at = stream_q.size() - 1;
        send_example();
    endtask

    // ------------------------------------------------------------------
    // Random tests under the different idling patterns.
    // ------------------------------------------------------------------
    task automatic test_no_idling();
        run_stream(0, 0, 280);
    endtask

    task automatic test_sparse_input();
        run_stream(88, 0, 280);
    endtask

    task automatic test_slow_output();
        run_stream(0, 88, 280);
    endtask

    task automatic test_both_idling();
        run_stream(20, 20, 280);
    endtask

    // The output side stops for a long stretch while bytes keep coming, so both
    // internal registers fill and the input must stall until the hold ends.
    task automatic test_backpressure();
        holds_asked++;
        run_stream(0, 0, 60);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, plus the long hold-off, which this process
    // counts down itself once a test asks for it.
    // ------------------------------------------------------------------
    int holds_done = 0;
    int hold_left  = 0;

    always @(negedge clk)
    begin
        if (holds_asked != holds_done)
        begin
            holds_done = holds_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else
            out_ready = !coin(recv_stall_pct);
    end

    function automatic string describe(input decoded_t it);
        return $sformatf("kind=%0d ns=%02h index=%08h value=%08h last=%0b",
                         it.kind, it.ns, it.idx, it.val, it.last);
    endfunction

    // Every result request taken is compared with the oldest pending prediction.
    always @(posedge clk)
    begin
        decoded_t seen;
        decoded_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen.kind = kind_t'(kind);
            seen.ns   = namespace_id;
            seen.idx  = feature_index;
            seen.val  = value_bits;
            seen.last = last_of_example;
            results_seen++;
            if (expected_items.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("Result %0d was not predicted: %s", results_seen, describe(seen));
            end
            else
            begin
                want = expected_items.pop_front();
                if (want.kind !== seen.kind || want.ns !== seen.ns || want.idx !== seen.idx ||
                    want.val !== seen.val || want.last !== seen.last)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("Result %0d mismatch: expected %s, got %s",
                                 results_seen, describe(want), describe(seen));
                end
            end
        end
    end

    // Hang detection: any cycle in which a request moves on either side restarts
    // the count. A leftover prediction that never arrives also ends up here.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("No request moved for %0d cycles; %0d results still outstanding",
                         quiet_cycles, expected_items.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        clear_state();
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_tail();
        test_feature_forms();
        test_overrun();
        test_truncated_long_count();
        test_no_idling();
        test_sparse_input();
        test_slow_output();
        test_both_idling();
        test_backpressure();

        @(negedge clk);
        in_valid = 1'b0;
        while (expected_items.size() != 0)
            @(posedge clk);
        // Let anything the block might still emit show up as an unpredicted result.
        repeat (10)
            @(posedge clk);

        $display("Streamed %0d bytes in %0d examples, %0d of them malformed or cut short.",
                 bytes_sent, examples, broken);
        $display("Checked %0d results, %0d overrun and %0d truncation reports among them.",
                 results_seen, overruns_due, truncations_due);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
